// File: rtl/core/nsfc_pkg.sv
`timescale 1ns / 1ps
package nsfc_pkg;

    // buffer sizes
    localparam int LINE_DEPTH  = 128;
    localparam int STORE_DEPTH = 128;
    localparam int NUM_TYPES   = 5;
    localparam int HDR_LEN     = 6;

    // fixed field widths
    localparam int TYPE_W = 3;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 8;

    // derived widths
    localparam int LA_W  = $clog2(LINE_DEPTH);
    localparam int POS_W = $clog2(LINE_DEPTH + 1);
    localparam int SL_W  = $clog2(STORE_DEPTH + 1);
    localparam int SA_W  = $clog2(NUM_TYPES * STORE_DEPTH);

    // sentence type codes
    localparam logic [TYPE_W-1:0] TYPE_GGA  = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_GSA  = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_GSV  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_RMC  = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_VTG  = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_NONE = 3'd5;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // framing characters
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [HDR_LEN-1:0][7:0] t_hdr;

    // known headers, byte 0 listed last
    localparam t_hdr HDR_TABLE [NUM_TYPES] = '{
        {8'h41, 8'h47, 8'h47, 8'h50, 8'h47, 8'h24},  // $GPGGA
        {8'h41, 8'h53, 8'h47, 8'h50, 8'h47, 8'h24},  // $GPGSA
        {8'h56, 8'h53, 8'h47, 8'h50, 8'h47, 8'h24},  // $GPGSV
        {8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24},  // $GPRMC
        {8'h47, 8'h54, 8'h56, 8'h50, 8'h47, 8'h24}   // $GPVTG
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept_byte;
        logic accept_read;
        logic copy;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_copy;
        logic copy_done;
        logic out_free;
    } t_stat;

    // header lookup, first match wins
    function automatic logic [TYPE_W-1:0] hdr_class(input t_hdr h);
        logic [TYPE_W-1:0] t;
        t = TYPE_NONE;
        for (int k = NUM_TYPES - 1; k >= 0; k--) begin
            if (h == HDR_TABLE[k]) begin
                t = TYPE_W'(k);
            end
        end
        return t;
    endfunction

    // first address of a type's store
    function automatic logic [SA_W-1:0] store_base(input logic [TYPE_W-1:0] t);
        return SA_W'(t) * SA_W'(STORE_DEPTH);
    endfunction

endpackage

// File: rtl/core/nsfc_ram.sv
`timescale 1ns / 1ps
module nsfc_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/nsfc_ctrl.sv
`timescale 1ns / 1ps
module nsfc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    input  nsfc_pkg::t_stat i_stat,
    output nsfc_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import nsfc_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_BYTE) begin
                        o_cmd.accept_byte = 1'b1;
                        n_state = i_stat.need_copy ? ST_COPY : ST_RESULT;
                    end else begin
                        o_cmd.accept_read = 1'b1;
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.copy = !i_stat.copy_done;
                if (i_stat.copy_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                o_cmd.push = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/core/nsfc_dp.sv
`timescale 1ns / 1ps
module nsfc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsfc_pkg::t_cmd                i_cmd,
    output nsfc_pkg::t_stat               o_stat,
    input  logic [7:0]                    i_rx_byte,
    input  logic [nsfc_pkg::TYPE_W-1:0]   i_read_type,
    input  logic [nsfc_pkg::IDX_W-1:0]    i_read_index,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_sentence_done,
    output logic [nsfc_pkg::TYPE_W-1:0]   o_sentence_type,
    output logic [nsfc_pkg::LEN_W-1:0]    o_line_length,
    output logic                          o_line_overflow,
    output logic [7:0]                    o_read_data,
    output logic [nsfc_pkg::LEN_W-1:0]    o_stored_length
);
    import nsfc_pkg::*;

    // framing state
    logic             r_in_sent;
    logic [POS_W-1:0] r_pos;
    logic             r_ovf;
    t_hdr             r_hdr;
    logic [SL_W-1:0]  r_slen [NUM_TYPES];

    // pending result of the current word
    logic              r_p_done;
    logic [TYPE_W-1:0] r_p_type;
    logic [POS_W-1:0]  r_p_len;
    logic              r_p_ovf;
    logic              r_p_hit;
    logic [SL_W-1:0]   r_p_slen;

    // copy engine
    logic [SL_W-1:0]  r_cidx;
    logic [SL_W-1:0]  r_ccnt;
    logic [SA_W-1:0]  r_base;
    logic             r_wv;
    logic [SL_W-1:0]  r_widx;

    // output register
    logic              r_out_valid;
    logic              r_o_done;
    logic [TYPE_W-1:0] r_o_type;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_ovf;
    logic [7:0]        r_o_rdata;
    logic [LEN_W-1:0]  r_o_slen;

    // byte word decode
    logic              w_stored;
    logic              w_sent_now;
    logic              w_end;
    logic [POS_W-1:0]  w_len;
    logic [TYPE_W-1:0] w_type;
    logic [SL_W-1:0]   w_copy_cnt;
    logic              w_ovf_now;

    // read word decode
    logic              w_sel_ok;
    logic [SL_W-1:0]   w_slen_sel;
    logic              w_hit;

    logic [7:0] w_line_q;
    logic [7:0] w_store_q;

    always_comb begin
        w_stored   = (r_pos < POS_W'(LINE_DEPTH));
        w_sent_now = r_in_sent || (i_rx_byte == CHAR_DOLLAR);
        w_end      = w_sent_now && (i_rx_byte == CHAR_NEWLINE);
        w_ovf_now  = r_ovf || (w_sent_now && !w_stored);
        w_len      = w_stored ? (r_pos + POS_W'(1)) : POS_W'(LINE_DEPTH);
        w_type     = (r_pos < POS_W'(HDR_LEN)) ? TYPE_NONE : hdr_class(r_hdr);
        w_copy_cnt = (32'(w_len) < STORE_DEPTH) ? SL_W'(w_len) : SL_W'(STORE_DEPTH);
    end

    always_comb begin
        w_sel_ok   = (i_read_type < TYPE_W'(NUM_TYPES));
        w_slen_sel = w_sel_ok ? r_slen[i_read_type] : '0;
        w_hit      = w_sel_ok && (SL_W'(i_read_index) < w_slen_sel)
                     && (32'(i_read_index) < STORE_DEPTH);
    end

    assign o_stat.need_copy = w_end && (w_type < TYPE_W'(NUM_TYPES));
    assign o_stat.copy_done = (r_cidx == r_ccnt);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // line buffer: written on byte words, read by the copy engine
    nsfc_ram #(
        .P_WIDTH (8),
        .P_DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept_byte && w_stored),
        .i_waddr (LA_W'(r_pos)),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.copy),
        .i_raddr (LA_W'(r_cidx)),
        .o_rdata (w_line_q)
    );

    // sentence stores: written by the copy engine, read on read words
    nsfc_ram #(
        .P_WIDTH (8),
        .P_DEPTH (NUM_TYPES * STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (r_wv),
        .i_waddr (r_base + SA_W'(r_widx)),
        .i_wdata (w_line_q),
        .i_re    (i_cmd.accept_read && w_hit),
        .i_raddr (store_base(i_read_type) + SA_W'(i_read_index)),
        .o_rdata (w_store_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sent   <= 1'b0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_cidx      <= '0;
            r_ccnt      <= '0;
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_slen[k] <= '0;
            end
        end else begin
            if (i_cmd.accept_byte) begin
                r_in_sent <= w_end ? 1'b0 : w_sent_now;
                r_ovf     <= w_end ? 1'b0 : w_ovf_now;
                if (w_end) begin
                    r_pos <= '0;
                end else if (w_sent_now && w_stored) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (o_stat.need_copy) begin
                    r_slen[w_type] <= w_copy_cnt;
                    r_ccnt         <= w_copy_cnt;
                    r_cidx         <= '0;
                end
            end
            if (i_cmd.copy) begin
                r_cidx <= r_cidx + SL_W'(1);
            end
            r_wv <= i_cmd.copy;
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_byte) begin
            for (int k = 0; k < HDR_LEN; k++) begin
                if (w_stored && (r_pos == POS_W'(k))) begin
                    r_hdr[k] <= i_rx_byte;
                end
            end
            r_p_done <= w_end;
            r_p_type <= w_end ? w_type : '0;
            r_p_len  <= w_end ? w_len : '0;
            r_p_ovf  <= w_end && w_ovf_now;
            r_p_hit  <= 1'b0;
            r_p_slen <= '0;
            r_base   <= store_base(w_type);
        end
        if (i_cmd.accept_read) begin
            r_p_done <= 1'b0;
            r_p_type <= '0;
            r_p_len  <= '0;
            r_p_ovf  <= 1'b0;
            r_p_hit  <= w_hit;
            r_p_slen <= w_slen_sel;
        end
        r_widx <= r_cidx;
        if (i_cmd.push) begin
            r_o_done  <= r_p_done;
            r_o_type  <= r_p_type;
            r_o_len   <= LEN_W'(r_p_len);
            r_o_ovf   <= r_p_ovf;
            r_o_rdata <= r_p_hit ? w_store_q : 8'd0;
            r_o_slen  <= LEN_W'(r_p_slen);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sentence_done = r_o_done;
    assign o_sentence_type = r_o_type;
    assign o_line_length   = r_o_len;
    assign o_line_overflow = r_o_ovf;
    assign o_read_data     = r_o_rdata;
    assign o_stored_length = r_o_slen;

endmodule

// File: rtl/core/nmea_sentence_framer_classifier.sv
`timescale 1ns / 1ps
// NMEA sentence framer and classifier.
// Input channel (i_in_valid / o_in_stall) carries one word: either a received
// serial byte (i_kind = 0) or a read request for one byte of a sentence store
// (i_kind = 1, i_read_type, i_read_index). Every word yields exactly one result
// word on the output channel (o_out_valid / i_out_stall).
// A byte word is written into the line buffer; a newline that closes a
// sentence with a known header ($GPGGA, $GPGSA, $GPGSV, $GPRMC, $GPVTG) starts
// a copy of the line into that type's store, one byte per cycle through the
// single read port of the line buffer.
// A read or an ordinary byte passes from the accept through the RESULT state
// into the output register; a copied sentence runs the COPY loop first.
// The block takes no new word before it is through with the last one, so the
// copy loop over the line buffer holds the input after a copied sentence.
// o_in_stall is high while a word is being worked on; a finished result waits
// in the output register while the receiver stalls, and the block holds the
// next word until that register frees.
// Reset (synchronous, active low) empties the line, clears all stored lengths
// and drops any pending result; no clearing pass is needed.
module nmea_sentence_framer_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [7:0]                  i_rx_byte,
    input  logic [nsfc_pkg::TYPE_W-1:0] i_read_type,
    input  logic [nsfc_pkg::IDX_W-1:0]  i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_sentence_done,
    output logic [nsfc_pkg::TYPE_W-1:0] o_sentence_type,
    output logic [nsfc_pkg::LEN_W-1:0]  o_line_length,
    output logic                        o_line_overflow,
    output logic [7:0]                  o_read_data,
    output logic [nsfc_pkg::LEN_W-1:0]  o_stored_length
);
    import nsfc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    nsfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (o_in_stall)
    );

    // framing, stores and output register
    nsfc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_rx_byte       (i_rx_byte),
        .i_read_type     (i_read_type),
        .i_read_index    (i_read_index),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sentence_done (o_sentence_done),
        .o_sentence_type (o_sentence_type),
        .o_line_length   (o_line_length),
        .o_line_overflow (o_line_overflow),
        .o_read_data     (o_read_data),
        .o_stored_length (o_stored_length)
    );

`ifndef ASSERT_OFF
    // one word at a time: an accepted word blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted while previous word still in work");

    // a recognized sentence holds at least header and newline
    a_known_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sentence_done && (o_sentence_type != TYPE_NONE))
        |-> (o_line_length >= LEN_W'(HDR_LEN + 1)))
        else $error("recognized sentence shorter than its header");

    // store data only comes from a non-empty store on a read word
    a_read_data_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_read_data != 8'd0))
        |-> ((o_stored_length != '0) && !o_sentence_done))
        else $error("read data from an empty store or a byte word");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// File: tb/nmea_sentence_framer_classifier_check.sv
`timescale 1ns / 1ps
module nmea_sentence_framer_classifier_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_kind,
    input  logic [7:0]                  i_rx_byte,
    input  logic [nsfc_pkg::TYPE_W-1:0] i_read_type,
    input  logic [nsfc_pkg::IDX_W-1:0]  i_read_index,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_sentence_done,
    input  logic [nsfc_pkg::TYPE_W-1:0] i_sentence_type,
    input  logic [nsfc_pkg::LEN_W-1:0]  i_line_length,
    input  logic                        i_line_overflow,
    input  logic [7:0]                  i_read_data,
    input  logic [nsfc_pkg::LEN_W-1:0]  i_stored_length,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_sentences,
    output int                          o_stored,
    output int                          o_overflows,
    output int                          o_reads
);
    import nsfc_pkg::*;

    // one result word as the block reports it
    typedef struct {
        logic              done;
        logic [TYPE_W-1:0] stype;
        logic [LEN_W-1:0]  len;
        logic              ovf;
        logic [7:0]        rdata;
        logic [LEN_W-1:0]  slen;
    } t_nmea_result;

    // known headers, first character in the top byte
    localparam logic [8*HDR_LEN-1:0] KNOWN_HDR [NUM_TYPES] = '{
        "$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG"
    };

    // shadow of the framer state
    logic         framing;
    int           fill;
    logic         dropped;
    logic [7:0]   line_mem [LINE_DEPTH];
    logic [7:0]   store_mem [NUM_TYPES][STORE_DEPTH];
    int           store_fill [NUM_TYPES];
    t_nmea_result result_q [$];

    int fails      = 0;
    int checked    = 0;
    int sentences  = 0;
    int stored     = 0;
    int overflows  = 0;
    int reads      = 0;

    // header lookup on the first six line bytes
    function automatic logic [TYPE_W-1:0] match_header();
        logic [8*HDR_LEN-1:0] head;
        if (fill < HDR_LEN) return TYPE_NONE;
        head = {line_mem[0], line_mem[1], line_mem[2],
                line_mem[3], line_mem[4], line_mem[5]};
        for (int t = 0; t < NUM_TYPES; t++) begin
            if (head == KNOWN_HDR[t]) return TYPE_W'(t);
        end
        return TYPE_NONE;
    endfunction

    // advance the shadow state by one word and give the result it causes
    function automatic t_nmea_result frame_word(input logic              kind,
                                                input logic [7:0]        b,
                                                input logic [TYPE_W-1:0] rtype,
                                                input logic [IDX_W-1:0]  ridx);
        t_nmea_result      r;
        logic              kept;
        int                n;
        logic [TYPE_W-1:0] t;
        r = '{done: 1'b0, stype: '0, len: '0, ovf: 1'b0, rdata: '0, slen: '0};
        if (kind == KIND_READ) begin
            if (rtype < NUM_TYPES) begin
                r.slen = LEN_W'(store_fill[rtype]);
                if (ridx < store_fill[rtype]) r.rdata = store_mem[rtype][ridx];
            end
        end else begin
            kept = (fill < LINE_DEPTH);
            if (kept) line_mem[fill] = b;
            if (b == CHAR_DOLLAR) framing = 1'b1;
            if (framing) begin
                if (!kept) dropped = 1'b1;
                if (b == CHAR_NEWLINE) begin
                    // line closes: classify, report and keep a copy if known
                    n = kept ? fill + 1 : LINE_DEPTH;
                    t = match_header();
                    r.done  = 1'b1;
                    r.stype = t;
                    r.len   = LEN_W'(n);
                    r.ovf   = dropped;
                    if (t != TYPE_NONE) begin
                        if (n > STORE_DEPTH) n = STORE_DEPTH;
                        for (int k = 0; k < n; k++) store_mem[t][k] = line_mem[k];
                        store_fill[t] = n;
                    end
                    framing = 1'b0;
                    fill    = 0;
                    dropped = 1'b0;
                end else if (kept) begin
                    fill++;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // watch both channels at each edge
    always @(posedge i_clk) begin : watch
        t_nmea_result got;
        t_nmea_result want;
        if (!i_rst_n) begin
            framing = 1'b0;
            fill    = 0;
            dropped = 1'b0;
            foreach (line_mem[k]) line_mem[k] = '0;
            foreach (store_mem[t, k]) store_mem[t][k] = '0;
            foreach (store_fill[t]) store_fill[t] = 0;
            result_q.delete();
        end else begin
            // result side first: nothing accepted at this edge can be out yet
            if (i_out_valid && !i_out_stall) begin
                got = '{done: i_sentence_done, stype: i_sentence_type,
                        len: i_line_length, ovf: i_line_overflow,
                        rdata: i_read_data, slen: i_stored_length};
                checked++;
                if (result_q.size() == 0) begin
                    fails++;
                    $display("%0t: result word with none expected, actual done %0d type %0d",
                             $time, got.done, got.stype);
                    $display("%0t:   actual len %0d rdata %0d slen %0d",
                             $time, got.len, got.rdata, got.slen);
                end else begin
                    want = result_q.pop_front();
                    check_field("sentence_done", want.done,  got.done);
                    check_field("sentence_type", want.stype, got.stype);
                    check_field("line_length",   want.len,   got.len);
                    check_field("line_overflow", want.ovf,   got.ovf);
                    check_field("read_data",     want.rdata, got.rdata);
                    check_field("stored_length", want.slen,  got.slen);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = frame_word(i_kind, i_rx_byte, i_read_type, i_read_index);
                result_q.push_back(want);
                if (i_kind == KIND_READ) reads++;
                if (want.done) sentences++;
                if (want.done && want.stype != TYPE_NONE) stored++;
                if (want.ovf) overflows++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
        o_checked    <= checked;
        o_sentences  <= sentences;
        o_stored     <= stored;
        o_overflows  <= overflows;
        o_reads      <= reads;
    end

endmodule

// File: tb/nmea_sentence_framer_classifier_test.sv
`timescale 1ns / 1ps
module nmea_sentence_framer_classifier_test;
    import nsfc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic              i_kind       = KIND_BYTE;
    logic [7:0]        i_rx_byte    = '0;
    logic [TYPE_W-1:0] i_read_type  = '0;
    logic [IDX_W-1:0]  i_read_index = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_sentence_done;
    logic [TYPE_W-1:0] o_sentence_type;
    logic [LEN_W-1:0]  o_line_length;
    logic              o_line_overflow;
    logic [7:0]        o_read_data;
    logic [LEN_W-1:0]  o_stored_length;

    int fail_count;
    int pending;
    int checked;
    int sentences;
    int stored;
    int overflows;
    int reads;

    int   cycle_count = 0;
    int   words_sent  = 0;
    int   stall_pct   = 0;
    int   hold_req    = 0;
    int   hold_done   = 0;
    int   stall_left  = 0;
    logic no_gaps     = 1'b0;

    string hdr_text [NUM_TYPES] = '{"$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG"};

    nmea_sentence_framer_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_rx_byte       (i_rx_byte),
        .i_read_type     (i_read_type),
        .i_read_index    (i_read_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sentence_done (o_sentence_done),
        .o_sentence_type (o_sentence_type),
        .o_line_length   (o_line_length),
        .o_line_overflow (o_line_overflow),
        .o_read_data     (o_read_data),
        .o_stored_length (o_stored_length)
    );

    nmea_sentence_framer_classifier_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_rx_byte       (i_rx_byte),
        .i_read_type     (i_read_type),
        .i_read_index    (i_read_index),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_sentence_done (o_sentence_done),
        .i_sentence_type (o_sentence_type),
        .i_line_length   (o_line_length),
        .i_line_overflow (o_line_overflow),
        .i_read_data     (o_read_data),
        .i_stored_length (o_stored_length),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_sentences     (sentences),
        .o_stored        (stored),
        .o_overflows     (overflows),
        .o_reads         (reads)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // result side stall: requested long hold-offs, rare random runs, else per-cycle
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done   <= hold_req;
            stall_left  <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(199) == 0) begin
            stall_left  <= $urandom_range(80, 20);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // sender gap after an accepted word
    function automatic int idle_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(90, 25);
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(input logic              kind,
                             input logic [7:0]        b,
                             input logic [TYPE_W-1:0] rtype,
                             input logic [IDX_W-1:0]  ridx);
        int gap;
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_rx_byte    <= b;
        i_read_type  <= rtype;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // unused fields carry random values
    task automatic send_byte(input logic [7:0] b);
        send_word(KIND_BYTE, b, TYPE_W'($urandom_range(7)), IDX_W'($urandom_range(127)));
    endtask

    task automatic send_read(input logic [TYPE_W-1:0] rtype, input logic [IDX_W-1:0] ridx);
        send_word(KIND_READ, 8'($urandom_range(255)), rtype, ridx);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // stop offering until every result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // a framed sentence: mostly a known header, sometimes a damaged one
    task automatic send_sentence();
        int         sel;
        int         bad;
        int         body;
        int         r;
        logic [7:0] c;
        sel = $urandom_range(NUM_TYPES - 1);
        if ($urandom_range(99) < 88) begin
            send_text(hdr_text[sel]);
        end else begin
            bad = $urandom_range(HDR_LEN - 1, 1);
            send_byte(CHAR_DOLLAR);
            for (int k = 1; k < HDR_LEN; k++) begin
                c = hdr_text[sel][k];
                if (k == bad) c = 8'($urandom_range(255));
                if (c == CHAR_NEWLINE) c = 8'h2A;
                send_byte(c);
            end
        end
        // body length: mostly short, a few around and past the line depth
        r = $urandom_range(99);
        if (r < 70) body = $urandom_range(30);
        else if (r < 92) body = $urandom_range(80, 31);
        else body = $urandom_range(140, 110);
        for (int k = 0; k < body; k++) begin
            c = 8'($urandom_range(255));
            if (c == CHAR_NEWLINE) c = 8'h2C;
            if ($urandom_range(49) == 0) c = CHAR_DOLLAR;
            send_byte(c);
        end
        send_byte(CHAR_NEWLINE);
    endtask

    // mix of sentences, store reads, line noise and cut-off headers
    task automatic random_traffic(input int words);
        int stop;
        int r;
        int n;
        stop = words_sent + words;
        while (words_sent < stop) begin
            r = $urandom_range(99);
            if (r < 62) begin
                send_sentence();
            end else if (r < 82) begin
                n = $urandom_range(4, 1);
                repeat (n) begin
                    send_read(($urandom_range(9) == 0) ? TYPE_W'($urandom_range(7, 5))
                                                       : TYPE_W'($urandom_range(4)),
                              ($urandom_range(9) < 7) ? IDX_W'($urandom_range(40))
                                                      : IDX_W'($urandom_range(127)));
                end
            end else if (r < 92) begin
                n = $urandom_range(6, 1);
                repeat (n) begin
                    send_byte(($urandom_range(4) == 0) ? CHAR_NEWLINE
                                                       : 8'($urandom_range(255)));
                end
            end else begin
                n = $urandom_range(HDR_LEN - 1);
                send_byte(CHAR_DOLLAR);
                for (int k = 1; k <= n; k++) begin
                    send_byte(hdr_text[$urandom_range(NUM_TYPES - 1)][k]);
                end
                send_byte(CHAR_NEWLINE);
            end
        end
    endtask

    // stimulus
    initial begin
        stall_pct <= 20;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, bad selector, minimal match, idle newline,
        // short line, zero byte and second dollar inside a sentence
        send_read(TYPE_GGA, 7'd0);
        send_read(3'd7, 7'd127);
        send_text("$GPGGA\n");
        send_read(TYPE_GGA, 7'd6);
        send_read(TYPE_GGA, 7'd7);
        send_byte(CHAR_NEWLINE);
        send_text("$G\n");
        send_byte(8'hFF);
        send_text("$GPRMC");
        send_byte(8'h00);
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_NEWLINE);
        send_read(TYPE_RMC, 7'd7);
        wait_drained();

        // back to back, result side always ready
        no_gaps   = 1'b1;
        stall_pct <= 0;
        random_traffic(250);
        wait_drained();

        // long receiver hold-off while words keep coming
        no_gaps   = 1'b0;
        stall_pct <= 30;
        hold_req  <= hold_req + 1;
        random_traffic(500);
        wait_drained();

        // heavy stall on both sides
        stall_pct <= 70;
        random_traffic(450);
        wait_drained();

        // dense input, light stall
        no_gaps   = 1'b1;
        stall_pct <= 15;
        random_traffic(400);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d words sent, %0d results checked, %0d store reads",
                 words_sent, checked, reads);
        $display("%0d sentences closed, %0d kept in a store, %0d with dropped bytes",
                 sentences, stored, overflows);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
